### hdl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants of the insertion sorter
// Set size, field widths, register map and the cell control struct.
// ----------------------------------------------------------------------------
package isc_pkg;

	// values per set
	localparam int COUNT   = 20;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 6;

	// configuration port
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic REG_DESCENDING = 1'b0;   // register index, taken from paddr[2]

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(COUNT - 1);

	// control that every cell of a chain sees
	typedef struct packed {
		logic load;    // insert the broadcast value this cycle
		logic shift;   // move every value one cell toward the head
	} isc_ctl_t;

endpackage

### hdl/isc_if.sv
// ----------------------------------------------------------------------------
// isc_item_if / isc_result_if: valid/ready channels of the sorter
// Input carries one value; output carries one sorted result.
// ----------------------------------------------------------------------------
interface isc_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface isc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] sorted_value;
	logic [5:0]  position;
	logic        last;

	modport source (output valid, output sorted_value, output position, output last,
		input ready);
	modport sink   (input valid, input sorted_value, input position, input last,
		output ready);
endinterface

### hdl/insertion_sorter_dir.sv
// ----------------------------------------------------------------------------
// insertion_sorter_dir: stable insertion sorter for sets of COUNT values
// Each accepted value is placed into two insertion chains, one
// kept ascending and one descending, both stable. The transaction that
// completes a set latches the order register and starts the drain: COUNT
// results, position 0 first, last set on the final one, one per cycle while
// the sink is ready, shifted out of the head of the chosen chain. Input is
// held off during the drain. Order register at byte address 0.
// ----------------------------------------------------------------------------
module insertion_sorter_dir import isc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	isc_item_if.sink          item,
	isc_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic             descending_q;
	logic             use_desc_q;
	logic             draining_q;
	logic [POS_W-1:0] fill_q;
	logic [POS_W-1:0] pos_q;
	logic             item_acc;
	logic             result_acc;
	logic             set_done;
	isc_ctl_t         ctl;
	logic [VAL_W-1:0] head_asc;
	logic [VAL_W-1:0] head_desc;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_DESCENDING) begin
			descending_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_DESCENDING) ? {{(DATA_W-1){1'b0}}, descending_q}
		: '0;

	// handshakes
	assign item.ready   = !draining_q;
	assign item_acc     = item.valid && !draining_q;
	assign result_acc   = draining_q && result.ready;
	assign set_done     = item_acc && fill_q == LAST_POS;
	assign ctl.load     = item_acc;
	assign ctl.shift    = result_acc;

	// fill count, drain control and latched order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			pos_q      <= '0;
			draining_q <= 1'b0;
			use_desc_q <= 1'b0;
		end else begin
			if (set_done) begin
				fill_q     <= '0;
				pos_q      <= '0;
				draining_q <= 1'b1;
				use_desc_q <= descending_q;
			end else if (item_acc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (result_acc) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == LAST_POS) begin
					draining_q <= 1'b0;
				end
			end
		end
	end

	// ascending and descending chains
	isc_chain u_chain_asc (
		.clk        (clk),
		.ctl        (ctl),
		.desc_order (1'b0),
		.fill       (fill_q),
		.x          (item.value),
		.head       (head_asc)
	);

	isc_chain u_chain_desc (
		.clk        (clk),
		.ctl        (ctl),
		.desc_order (1'b1),
		.fill       (fill_q),
		.x          (item.value),
		.head       (head_desc)
	);

	// result from the chosen head
	assign result.valid        = draining_q;
	assign result.sorted_value = use_desc_q ? head_desc : head_asc;
	assign result.position     = pos_q;
	assign result.last         = pos_q == LAST_POS;

	// no insertion while draining, set start empty
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> fill_q == '0)
		else $error("fill count not empty during drain");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LAST_POS)
		else $error("fill count beyond set size");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_acc && result.last) |=> (item.ready && pos_q == '0 || pos_q == POS_W'(COUNT)))
		else $error("drain did not end after last result");

	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		set_done |=> (draining_q && pos_q == '0))
		else $error("completed set did not start draining");

endmodule

### hdl/isc_cell.sv
// ----------------------------------------------------------------------------
// isc_cell: one slot of the insertion chain
// Holds one value; on insert it keeps its value, takes the new one or takes
// its upper neighbor's; on drain it takes its lower neighbor's value.
// ----------------------------------------------------------------------------
module isc_cell import isc_pkg::*; (
	input  logic             clk,
	input  isc_ctl_t         ctl,
	input  logic             desc_order,
	input  logic             occupied,
	input  logic [VAL_W-1:0] x,
	input  logic [VAL_W-1:0] prev_val,
	input  logic             prev_ins,
	input  logic [VAL_W-1:0] next_val,
	output logic [VAL_W-1:0] val,
	output logic             ins
);

	logic [VAL_W-1:0] val_q;

	// new value belongs in front of this slot (strict compare keeps ties stable)
	always_comb begin
		ins = !occupied || (desc_order ? (val_q < x) : (val_q > x));
	end

	// insert or drain
	always_ff @(posedge clk) begin
		if (ctl.load && ins) begin
			val_q <= prev_ins ? prev_val : x;
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule

### hdl/isc_chain.sv
// ----------------------------------------------------------------------------
// isc_chain: row of COUNT insertion cells kept in one fixed order
// The head cell holds sorted position 0.
// ----------------------------------------------------------------------------
module isc_chain import isc_pkg::*; (
	input  logic             clk,
	input  isc_ctl_t         ctl,
	input  logic             desc_order,
	input  logic [POS_W-1:0] fill,
	input  logic [VAL_W-1:0] x,
	output logic [VAL_W-1:0] head
);

	logic [VAL_W-1:0] val [COUNT];
	logic [COUNT-1:0] ins;
	logic [COUNT-1:0] occupied;

	for (genvar i = 0; i < COUNT; i++) begin : g_cell
		logic [VAL_W-1:0] prev_val;
		logic             prev_ins;
		logic [VAL_W-1:0] next_val;

		assign occupied[i] = POS_W'(i) < fill;

		if (i == 0) begin : g_head
			assign prev_val = x;
			assign prev_ins = 1'b0;
		end else begin : g_body
			assign prev_val = val[i-1];
			assign prev_ins = ins[i-1];
		end

		if (i == COUNT - 1) begin : g_tail
			assign next_val = val[i];
		end else begin : g_mid
			assign next_val = val[i+1];
		end

		isc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.desc_order (desc_order),
			.occupied   (occupied[i]),
			.x          (x),
			.prev_val   (prev_val),
			.prev_ins   (prev_ins),
			.next_val   (next_val),
			.val        (val[i]),
			.ins        (ins[i])
		);
	end

	assign head = val[0];

endmodule
